[src/tnaa_pkg.sv]
// Shared types, constants and helper functions for the triangle normal area accumulator.
// No dependencies; the front end, back end, normalizer and top files import this package.
package tnaa_pkg;

    // Storage geometry.
    localparam int VERTEX_SLOTS = 4096;
    localparam int COORD_BITS   = 24;
    localparam int ADDR_W       = $clog2(VERTEX_SLOTS);
    localparam int SLOT_W       = 12;
    localparam int POS_W        = 24;
    localparam int VTX_W        = 3 * COORD_BITS;
    localparam int SUM_W        = 64;
    localparam int SUMS_W       = 3 * SUM_W;

    // Datapath widths.
    localparam int DIFF_W  = POS_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int UNIT_W  = 16;
    localparam int AREA_W  = 51;
    localparam int SQ_W    = 2 * SUM_W;
    localparam int SSUM_W  = SQ_W + 2;
    localparam int QUOT_W  = 33;
    localparam int ROOT_W  = 52;
    localparam int SOP_W   = 2 * ROOT_W;
    localparam int SREM_W  = ROOT_W + 2;

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Operation codes of an input beat.
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_TRI  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // Result kinds.
    localparam logic RK_TRI    = 1'b0;
    localparam logic RK_NORMAL = 1'b1;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_TRI,
        CMD_READ
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic               slot_ok;
        logic [SLOT_W-1:0]  slot;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic               c0_ok;
        logic               c1_ok;
        logic               c2_ok;
        logic [SLOT_W-1:0]  c0;
        logic [SLOT_W-1:0]  c1;
        logic [SLOT_W-1:0]  c2;
    } cmd_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] y;
        logic signed [SUM_W-1:0] z;
        logic                    want_area;
    } norm_req_t;

    typedef struct packed {
        logic signed [UNIT_W-1:0] unit_x;
        logic signed [UNIT_W-1:0] unit_y;
        logic signed [UNIT_W-1:0] unit_z;
        logic [AREA_W-1:0]        area;
        logic                     degenerate;
    } norm_rsp_t;

    // True when a slot number addresses a stored vertex.
    function automatic logic slot_in_range(logic [SLOT_W-1:0] s);
        logic [31:0] w;
        w = {{(32 - SLOT_W){1'b0}}, s};
        return w < 32'(VERTEX_SLOTS);
    endfunction

    // Memory address of a slot number.
    function automatic logic [ADDR_W-1:0] slot_addr(logic [SLOT_W-1:0] s);
        logic [SLOT_W+ADDR_W-1:0] w;
        w = {{ADDR_W{1'b0}}, s};
        return w[ADDR_W-1:0];
    endfunction

    // Stored coordinate as a signed value of the position width.
    function automatic logic signed [POS_W-1:0] coord_sext(logic [COORD_BITS-1:0] c);
        logic signed [COORD_BITS-1:0] t;
        t = c;
        return POS_W'(t);
    endfunction

endpackage

[src/tnaa_ram.sv]
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
module tnaa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/tnaa_front.sv]
// Front end: accepts input beats, classifies them and queues commands for the back end.
// Depends on tnaa_pkg.
module tnaa_front
    import tnaa_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_operation,
    input  logic [SLOT_W-1:0]       s_vertex_slot,
    input  logic signed [POS_W-1:0] s_pos_x_in,
    input  logic signed [POS_W-1:0] s_pos_y_in,
    input  logic signed [POS_W-1:0] s_pos_z_in,
    input  logic [SLOT_W-1:0]       s_corner_first,
    input  logic [SLOT_W-1:0]       s_corner_second,
    input  logic [SLOT_W-1:0]       s_corner_third,
    output logic                    cmd_valid,
    output cmd_t                    cmd,
    input  logic                    cmd_pop
);

    cmd_t              queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    cmd_t              new_cmd;
    logic              keep;
    logic              push;

    // Classify the beat; unused codes and out-of-range loads are dropped here.
    always_comb begin
        new_cmd         = '0;
        new_cmd.slot    = s_vertex_slot;
        new_cmd.slot_ok = slot_in_range(s_vertex_slot);
        new_cmd.pos_x   = s_pos_x_in;
        new_cmd.pos_y   = s_pos_y_in;
        new_cmd.pos_z   = s_pos_z_in;
        new_cmd.c0      = s_corner_first;
        new_cmd.c1      = s_corner_second;
        new_cmd.c2      = s_corner_third;
        new_cmd.c0_ok   = slot_in_range(s_corner_first);
        new_cmd.c1_ok   = slot_in_range(s_corner_second);
        new_cmd.c2_ok   = slot_in_range(s_corner_third);
        keep            = 1'b0;
        unique case (s_operation)
            OP_LOAD: begin
                new_cmd.kind = CMD_LOAD;
                keep         = new_cmd.slot_ok;
            end
            OP_TRI: begin
                new_cmd.kind = CMD_TRI;
                keep         = 1'b1;
            end
            OP_READ: begin
                new_cmd.kind = CMD_READ;
                keep         = 1'b1;
            end
            default: begin
                new_cmd.kind = CMD_LOAD;
                keep         = 1'b0;
            end
        endcase
    end

    assign s_ready    = count_reg != (QPTR_W + 1)'(QUEUE_DEPTH);
    assign push       = s_valid && s_ready && keep;
    assign count_next = count_reg + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(cmd_pop);

    // Queue pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (cmd_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= new_cmd;
        end
    end

    assign cmd_valid = count_reg != '0;
    assign cmd       = queue_reg[rd_ptr_reg];

endmodule

[src/tnaa_norm.sv]
// Normalizer: squares, exact length sum, per-component quotient and root, rounded length.
// Depends on tnaa_pkg.
module tnaa_norm
    import tnaa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      start,
    input  norm_req_t req,
    output logic      done,
    output norm_rsp_t rsp
);

    typedef enum logic [3:0] {
        N_IDLE,
        N_MUL,
        N_ACC,
        N_DIV_INIT,
        N_DIV,
        N_SQ_INIT,
        N_SQ,
        N_UNIT,
        N_AREA_INIT,
        N_AREA_FIN,
        N_DONE
    } nstate_t;

    nstate_t             state_reg;
    logic [1:0]          comp_reg;
    logic [1:0]          part_reg;
    logic [5:0]          cnt_reg;
    logic                area_phase_reg;
    logic                want_area_reg;
    logic [SUM_W-1:0]    mag_reg [3];
    logic                neg_reg [3];
    logic [SQ_W-1:0]     sq_reg [3];
    logic [SSUM_W-1:0]   s_reg;
    logic [63:0]         prod_reg;
    logic [SSUM_W-1:0]   drem_reg;
    logic [QUOT_W-1:0]   dnum_reg;
    logic [QUOT_W-1:0]   quot_reg;
    logic [SOP_W-1:0]    sop_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [SREM_W-1:0]   srem_reg;
    norm_rsp_t           rsp_reg;

    logic [SUM_W-1:0]    cur_mag;
    logic [31:0]         mul_a;
    logic [31:0]         mul_b;
    logic [63:0]         mul_p;
    logic [SSUM_W-1:0]   add_term;
    logic [SSUM_W:0]     dsh;
    logic [SSUM_W:0]     ddiff;
    logic                dge;
    logic [SREM_W+1:0]   st;
    logic [SREM_W+1:0]   strial;
    logic [SREM_W+1:0]   sdiff;
    logic                sge;
    logic [17:0]         qsum;
    logic [16:0]         q;
    logic [16:0]         qneg;
    logic [UNIT_W-1:0]   unit_val;
    logic [ROOT_W:0]     root_inc;
    logic [SUM_W-1:0]    in_mag [3];
    logic                in_zero;

    // Magnitudes of the incoming vector.
    assign in_mag[0] = req.x[SUM_W-1] ? (~req.x + 1'b1) : req.x;
    assign in_mag[1] = req.y[SUM_W-1] ? (~req.y + 1'b1) : req.y;
    assign in_mag[2] = req.z[SUM_W-1] ? (~req.z + 1'b1) : req.z;
    assign in_zero   = (req.x == '0) && (req.y == '0) && (req.z == '0);

    // Half-word partial products of one square.
    always_comb begin
        unique case (comp_reg)
            2'd0:    cur_mag = mag_reg[0];
            2'd1:    cur_mag = mag_reg[1];
            default: cur_mag = mag_reg[2];
        endcase
        mul_a = (part_reg == 2'd2) ? cur_mag[63:32] : cur_mag[31:0];
        mul_b = (part_reg == 2'd0) ? cur_mag[31:0] : cur_mag[63:32];
        unique case (part_reg)
            2'd0:    add_term = {66'd0, prod_reg};
            2'd1:    add_term = {33'd0, prod_reg, 33'd0};
            default: add_term = {2'd0, prod_reg, 64'd0};
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // One restoring division step.
    assign dsh   = {drem_reg, dnum_reg[QUOT_W-1]};
    assign ddiff = dsh - {1'b0, s_reg};
    assign dge   = dsh >= {1'b0, s_reg};

    // One digit of the square root.
    assign st     = {srem_reg, sop_reg[SOP_W-1:SOP_W-2]};
    assign strial = {2'd0, root_reg, 2'b01};
    assign sdiff  = st - strial;
    assign sge    = st >= strial;

    // Unit component from the quotient root: round to nearest, saturate the positive end.
    assign qsum = {1'b0, root_reg[16:0]} + 18'd1;
    assign q    = qsum[17:1];
    assign qneg = 17'd0 - q;
    always_comb begin
        if (neg_reg[comp_reg]) begin
            unit_val = qneg[UNIT_W-1:0];
        end else if (q > 17'd32767) begin
            unit_val = 16'h7FFF;
        end else begin
            unit_val = q[UNIT_W-1:0];
        end
    end

    assign root_inc = {1'b0, root_reg} + {{ROOT_W{1'b0}}, 1'b1};

    // Sequencer and datapath registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= N_IDLE;
        end else begin
            unique case (state_reg)
                N_IDLE: begin
                    if (start) begin
                        for (int k = 0; k < 3; k++) begin
                            mag_reg[k] <= in_mag[k];
                            sq_reg[k]  <= '0;
                        end
                        neg_reg[0]     <= req.x[SUM_W-1];
                        neg_reg[1]     <= req.y[SUM_W-1];
                        neg_reg[2]     <= req.z[SUM_W-1];
                        s_reg          <= '0;
                        comp_reg       <= 2'd0;
                        part_reg       <= 2'd0;
                        want_area_reg  <= req.want_area;
                        area_phase_reg <= 1'b0;
                        // A zero vector finishes at once with only the degenerate flag set.
                        rsp_reg        <= {{(3 * UNIT_W + AREA_W){1'b0}}, in_zero};
                        if (in_zero) begin
                            state_reg <= N_DONE;
                        end else begin
                            state_reg <= N_MUL;
                        end
                    end
                end
                N_MUL: begin
                    prod_reg  <= mul_p;
                    state_reg <= N_ACC;
                end
                N_ACC: begin
                    sq_reg[comp_reg] <= sq_reg[comp_reg] + add_term[SQ_W-1:0];
                    s_reg            <= s_reg + add_term;
                    if (part_reg == 2'd2) begin
                        part_reg <= 2'd0;
                        if (comp_reg == 2'd2) begin
                            comp_reg  <= 2'd0;
                            state_reg <= N_DIV_INIT;
                        end else begin
                            comp_reg  <= comp_reg + 2'd1;
                            state_reg <= N_MUL;
                        end
                    end else begin
                        part_reg  <= part_reg + 2'd1;
                        state_reg <= N_MUL;
                    end
                end
                N_DIV_INIT: begin
                    drem_reg  <= {3'd0, sq_reg[comp_reg][SQ_W-1:1]};
                    dnum_reg  <= {sq_reg[comp_reg][0], 32'd0};
                    quot_reg  <= '0;
                    cnt_reg   <= '0;
                    state_reg <= N_DIV;
                end
                N_DIV: begin
                    drem_reg <= dge ? ddiff[SSUM_W-1:0] : dsh[SSUM_W-1:0];
                    quot_reg <= {quot_reg[QUOT_W-2:0], dge};
                    dnum_reg <= {dnum_reg[QUOT_W-2:0], 1'b0};
                    cnt_reg  <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(QUOT_W - 1)) begin
                        state_reg <= N_SQ_INIT;
                    end
                end
                N_SQ_INIT: begin
                    sop_reg   <= {1'b0, quot_reg, {(SOP_W - QUOT_W - 1){1'b0}}};
                    root_reg  <= '0;
                    srem_reg  <= '0;
                    cnt_reg   <= '0;
                    state_reg <= N_SQ;
                end
                N_SQ: begin
                    srem_reg <= sge ? sdiff[SREM_W-1:0] : st[SREM_W-1:0];
                    root_reg <= {root_reg[ROOT_W-2:0], sge};
                    sop_reg  <= {sop_reg[SOP_W-3:0], 2'b00};
                    cnt_reg  <= cnt_reg + 6'd1;
                    if (area_phase_reg && cnt_reg == 6'(ROOT_W - 1)) begin
                        state_reg <= N_AREA_FIN;
                    end else if (!area_phase_reg && cnt_reg == 6'd16) begin
                        state_reg <= N_UNIT;
                    end
                end
                N_UNIT: begin
                    unique case (comp_reg)
                        2'd0:    rsp_reg.unit_x <= unit_val;
                        2'd1:    rsp_reg.unit_y <= unit_val;
                        default: rsp_reg.unit_z <= unit_val;
                    endcase
                    if (comp_reg == 2'd2) begin
                        state_reg <= want_area_reg ? N_AREA_INIT : N_DONE;
                    end else begin
                        comp_reg  <= comp_reg + 2'd1;
                        state_reg <= N_DIV_INIT;
                    end
                end
                N_AREA_INIT: begin
                    sop_reg        <= s_reg[SOP_W-1:0];
                    root_reg       <= '0;
                    srem_reg       <= '0;
                    cnt_reg        <= '0;
                    area_phase_reg <= 1'b1;
                    state_reg      <= N_SQ;
                end
                N_AREA_FIN: begin
                    // Round up when the remainder exceeds the root.
                    if (srem_reg > {2'd0, root_reg}) begin
                        rsp_reg.area <= root_inc[AREA_W-1:0];
                    end else begin
                        rsp_reg.area <= root_reg[AREA_W-1:0];
                    end
                    state_reg <= N_DONE;
                end
                N_DONE: begin
                    state_reg <= N_IDLE;
                end
                default: begin
                    state_reg <= N_IDLE;
                end
            endcase
        end
    end

    assign done = state_reg == N_DONE;
    assign rsp  = rsp_reg;

endmodule

[src/tnaa_back.sv]
// Back end: vertex and accumulator stores, cross product, saturating updates, result register.
// Depends on tnaa_pkg and tnaa_ram; drives the normalizer through its request struct.
module tnaa_back
    import tnaa_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cmd_valid,
    input  cmd_t                     cmd,
    output logic                     cmd_pop,
    output logic                     norm_start,
    output norm_req_t                norm_req,
    input  logic                     norm_done,
    input  norm_rsp_t                norm_rsp,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_result_kind,
    output logic signed [UNIT_W-1:0] m_unit_x,
    output logic signed [UNIT_W-1:0] m_unit_y,
    output logic signed [UNIT_W-1:0] m_unit_z,
    output logic [AREA_W-1:0]        m_double_area,
    output logic                     m_degenerate
);

    typedef enum logic [3:0] {
        B_IDLE,
        B_VRD,
        B_DIFF,
        B_CROSS,
        B_ACC_RD,
        B_ACC_WR,
        B_SUM_RD,
        B_SUM_CAP,
        B_NORM_GO,
        B_NORM_WAIT,
        B_OUT
    } bstate_t;

    bstate_t                     state_reg;
    logic [1:0]                  vcnt_reg;
    logic [2:0]                  mcnt_reg;
    logic [1:0]                  acnt_reg;
    logic                        bad_read_reg;
    logic signed [POS_W-1:0]     px_reg [3];
    logic signed [POS_W-1:0]     py_reg [3];
    logic signed [POS_W-1:0]     pz_reg [3];
    logic signed [DIFF_W-1:0]    ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [CROSS_W-1:0]   cx_reg, cy_reg, cz_reg;
    logic signed [SUM_W-1:0]     rx_reg, ry_reg, rz_reg;
    logic                        m_valid_reg;
    logic                        kind_reg;
    norm_rsp_t                   out_reg;

    logic [ADDR_W-1:0]           vram_raddr;
    logic [VTX_W-1:0]            vram_rdata;
    logic                        vram_we;
    logic [VTX_W-1:0]            vram_wdata;
    logic [ADDR_W-1:0]           sram_raddr;
    logic [ADDR_W-1:0]           sram_waddr;
    logic [SUMS_W-1:0]           sram_rdata;
    logic [SUMS_W-1:0]           sram_wdata;
    logic                        sram_we;
    logic [SLOT_W-1:0]           vsel;
    logic [SLOT_W-1:0]           asel;
    logic                        asel_ok;
    logic signed [DIFF_W-1:0]    mul_a;
    logic signed [DIFF_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]    mul_p;
    logic signed [CROSS_W-1:0]   prod_ext;
    logic signed [POS_W-1:0]     rd_x, rd_y, rd_z;
    logic                        out_free;
    logic                        out_load;
    logic [2:0]                  midx;

    // Adds with clamping at the signed 64-bit limits.
    function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
        if (s[SUM_W] != s[SUM_W-1]) begin
            return s[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
        end
        return s[SUM_W-1:0];
    endfunction

    // Vertex position store, x in the low bits.
    tnaa_ram #(
        .WIDTH(VTX_W),
        .DEPTH(VERTEX_SLOTS)
    ) u_vtx_ram (
        .aclk  (aclk),
        .we    (vram_we),
        .waddr (slot_addr(cmd.slot)),
        .wdata (vram_wdata),
        .raddr (vram_raddr),
        .rdata (vram_rdata)
    );

    // Normal accumulator store, x in the low bits.
    tnaa_ram #(
        .WIDTH(SUMS_W),
        .DEPTH(VERTEX_SLOTS)
    ) u_sum_ram (
        .aclk  (aclk),
        .we    (sram_we),
        .waddr (sram_waddr),
        .wdata (sram_wdata),
        .raddr (sram_raddr),
        .rdata (sram_rdata)
    );

    // Corner selection for position reads and accumulator updates.
    always_comb begin
        unique case (vcnt_reg)
            2'd0:    vsel = cmd.c0;
            2'd1:    vsel = cmd.c1;
            default: vsel = cmd.c2;
        endcase
        unique case (acnt_reg)
            2'd0: begin
                asel    = cmd.c0;
                asel_ok = cmd.c0_ok;
            end
            2'd1: begin
                asel    = cmd.c1;
                asel_ok = cmd.c1_ok;
            end
            default: begin
                asel    = cmd.c2;
                asel_ok = cmd.c2_ok;
            end
        endcase
    end

    assign vram_raddr = slot_addr(vsel);
    assign sram_raddr = (state_reg == B_SUM_RD) ? slot_addr(cmd.slot) : slot_addr(asel);

    // Load beats write the position and clear the accumulator.
    assign vram_we    = (state_reg == B_IDLE) && cmd_valid && (cmd.kind == CMD_LOAD);
    assign vram_wdata = {cmd.pos_z[COORD_BITS-1:0], cmd.pos_y[COORD_BITS-1:0],
                         cmd.pos_x[COORD_BITS-1:0]};

    // Accumulator write: cleared on a load, saturating add on a triangle corner.
    always_comb begin
        sram_we    = 1'b0;
        sram_waddr = slot_addr(asel);
        sram_wdata = '0;
        if (vram_we) begin
            sram_we    = 1'b1;
            sram_waddr = slot_addr(cmd.slot);
        end else if (state_reg == B_ACC_WR) begin
            sram_we    = 1'b1;
            sram_wdata = {sat_add(sram_rdata[3*SUM_W-1:2*SUM_W], SUM_W'(cz_reg)),
                          sat_add(sram_rdata[2*SUM_W-1:SUM_W], SUM_W'(cy_reg)),
                          sat_add(sram_rdata[SUM_W-1:0], SUM_W'(cx_reg))};
        end
    end

    // Stored coordinates as signed values for arithmetic.
    assign rd_x = coord_sext(vram_rdata[COORD_BITS-1:0]);
    assign rd_y = coord_sext(vram_rdata[2*COORD_BITS-1:COORD_BITS]);
    assign rd_z = coord_sext(vram_rdata[3*COORD_BITS-1:2*COORD_BITS]);

    // Cross product operand selection, one product per cycle.
    always_comb begin
        unique case (mcnt_reg)
            3'd0: begin
                mul_a = ay_reg;
                mul_b = bz_reg;
            end
            3'd1: begin
                mul_a = az_reg;
                mul_b = by_reg;
            end
            3'd2: begin
                mul_a = az_reg;
                mul_b = bx_reg;
            end
            3'd3: begin
                mul_a = ax_reg;
                mul_b = bz_reg;
            end
            3'd4: begin
                mul_a = ax_reg;
                mul_b = by_reg;
            end
            3'd5: begin
                mul_a = ay_reg;
                mul_b = bx_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign prod_ext = CROSS_W'(prod_reg);
    assign midx     = mcnt_reg - 3'd1;

    // Request to the normalizer: the cross product or the captured accumulator.
    always_comb begin
        if (cmd.kind == CMD_TRI) begin
            norm_req.x         = SUM_W'(cx_reg);
            norm_req.y         = SUM_W'(cy_reg);
            norm_req.z         = SUM_W'(cz_reg);
            norm_req.want_area = 1'b1;
        end else begin
            norm_req.x         = rx_reg;
            norm_req.y         = ry_reg;
            norm_req.z         = rz_reg;
            norm_req.want_area = 1'b0;
        end
    end

    assign norm_start = state_reg == B_NORM_GO;
    assign out_free   = !m_valid_reg || m_ready;
    assign out_load   = (state_reg == B_OUT) && out_free;
    assign cmd_pop    = vram_we || out_load;

    // Command sequencer and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            m_valid_reg  <= 1'b0;
            bad_read_reg <= 1'b0;
        end else begin
            // A new result replaces the one taken in the same cycle.
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE: begin
                    if (cmd_valid) begin
                        unique case (cmd.kind)
                            CMD_TRI: begin
                                vcnt_reg  <= 2'd0;
                                state_reg <= B_VRD;
                            end
                            CMD_READ: begin
                                if (cmd.slot_ok) begin
                                    state_reg <= B_SUM_RD;
                                end else begin
                                    bad_read_reg <= 1'b1;
                                    state_reg    <= B_OUT;
                                end
                            end
                            default: begin
                                state_reg <= B_IDLE;
                            end
                        endcase
                    end
                end
                B_VRD: begin
                    // Each corner's data arrives the cycle after its address.
                    unique case (vcnt_reg)
                        2'd1: begin
                            px_reg[0] <= cmd.c0_ok ? rd_x : '0;
                            py_reg[0] <= cmd.c0_ok ? rd_y : '0;
                            pz_reg[0] <= cmd.c0_ok ? rd_z : '0;
                        end
                        2'd2: begin
                            px_reg[1] <= cmd.c1_ok ? rd_x : '0;
                            py_reg[1] <= cmd.c1_ok ? rd_y : '0;
                            pz_reg[1] <= cmd.c1_ok ? rd_z : '0;
                        end
                        2'd3: begin
                            px_reg[2] <= cmd.c2_ok ? rd_x : '0;
                            py_reg[2] <= cmd.c2_ok ? rd_y : '0;
                            pz_reg[2] <= cmd.c2_ok ? rd_z : '0;
                        end
                        default: begin
                            px_reg[0] <= px_reg[0];
                        end
                    endcase
                    vcnt_reg <= vcnt_reg + 2'd1;
                    if (vcnt_reg == 2'd3) begin
                        state_reg <= B_DIFF;
                    end
                end
                B_DIFF: begin
                    ax_reg    <= DIFF_W'(px_reg[1]) - DIFF_W'(px_reg[0]);
                    ay_reg    <= DIFF_W'(py_reg[1]) - DIFF_W'(py_reg[0]);
                    az_reg    <= DIFF_W'(pz_reg[1]) - DIFF_W'(pz_reg[0]);
                    bx_reg    <= DIFF_W'(px_reg[2]) - DIFF_W'(px_reg[0]);
                    by_reg    <= DIFF_W'(py_reg[2]) - DIFF_W'(py_reg[0]);
                    bz_reg    <= DIFF_W'(pz_reg[2]) - DIFF_W'(pz_reg[0]);
                    mcnt_reg  <= 3'd0;
                    state_reg <= B_CROSS;
                end
                B_CROSS: begin
                    prod_reg <= mul_p;
                    if (mcnt_reg != 3'd0) begin
                        unique case (midx)
                            3'd0:    cx_reg <= prod_ext;
                            3'd1:    cx_reg <= cx_reg - prod_ext;
                            3'd2:    cy_reg <= prod_ext;
                            3'd3:    cy_reg <= cy_reg - prod_ext;
                            3'd4:    cz_reg <= prod_ext;
                            default: cz_reg <= cz_reg - prod_ext;
                        endcase
                    end
                    mcnt_reg <= mcnt_reg + 3'd1;
                    if (mcnt_reg == 3'd6) begin
                        acnt_reg  <= 2'd0;
                        state_reg <= B_ACC_RD;
                    end
                end
                B_ACC_RD: begin
                    // Corners outside the store skip their update.
                    if (asel_ok) begin
                        state_reg <= B_ACC_WR;
                    end else if (acnt_reg == 2'd2) begin
                        state_reg <= B_NORM_GO;
                    end else begin
                        acnt_reg <= acnt_reg + 2'd1;
                    end
                end
                B_ACC_WR: begin
                    if (acnt_reg == 2'd2) begin
                        state_reg <= B_NORM_GO;
                    end else begin
                        acnt_reg  <= acnt_reg + 2'd1;
                        state_reg <= B_ACC_RD;
                    end
                end
                B_SUM_RD: begin
                    state_reg <= B_SUM_CAP;
                end
                B_SUM_CAP: begin
                    rx_reg    <= sram_rdata[SUM_W-1:0];
                    ry_reg    <= sram_rdata[2*SUM_W-1:SUM_W];
                    rz_reg    <= sram_rdata[3*SUM_W-1:2*SUM_W];
                    state_reg <= B_NORM_GO;
                end
                B_NORM_GO: begin
                    state_reg <= B_NORM_WAIT;
                end
                B_NORM_WAIT: begin
                    if (norm_done) begin
                        state_reg <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (out_free) begin
                        kind_reg     <= (cmd.kind == CMD_READ) ? RK_NORMAL : RK_TRI;
                        bad_read_reg <= 1'b0;
                        if (bad_read_reg) begin
                            out_reg <= {{(3 * UNIT_W + AREA_W){1'b0}}, 1'b1};
                        end else begin
                            out_reg <= norm_rsp;
                        end
                        state_reg <= B_IDLE;
                    end
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_kind = kind_reg;
    assign m_unit_x      = out_reg.unit_x;
    assign m_unit_y      = out_reg.unit_y;
    assign m_unit_z      = out_reg.unit_z;
    assign m_double_area = out_reg.area;
    assign m_degenerate  = out_reg.degenerate;

endmodule

[src/triangle_normal_area_accumulator_top.sv]
// Triangle normal area accumulator. Load beats are written by the back end in its idle state; triangles
// and normal reads go through the shared divider (33 steps per component) and the digit-serial
// root (17 steps per component, 52 for the length).
// One command is carried out at a time; a two-entry queue and the result register let both
// channels stall independently. Reset (aresetn, synchronous) empties the queue and the
// sequencers; the vertex and accumulator stores are not cleared and hold data only once loaded.
// Depends on tnaa_pkg, tnaa_front, tnaa_back, tnaa_norm and tnaa_ram.
module triangle_normal_area_accumulator_top
    import tnaa_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_operation,
    input  logic [SLOT_W-1:0]        s_vertex_slot,
    input  logic signed [POS_W-1:0]  s_pos_x_in,
    input  logic signed [POS_W-1:0]  s_pos_y_in,
    input  logic signed [POS_W-1:0]  s_pos_z_in,
    input  logic [SLOT_W-1:0]        s_corner_first,
    input  logic [SLOT_W-1:0]        s_corner_second,
    input  logic [SLOT_W-1:0]        s_corner_third,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_result_kind,
    output logic signed [UNIT_W-1:0] m_unit_x,
    output logic signed [UNIT_W-1:0] m_unit_y,
    output logic signed [UNIT_W-1:0] m_unit_z,
    output logic [AREA_W-1:0]        m_double_area,
    output logic                     m_degenerate
);

    logic      cmd_valid;
    cmd_t      cmd;
    logic      cmd_pop;
    logic      norm_start;
    norm_req_t norm_req;
    logic      norm_done;
    norm_rsp_t norm_rsp;

    // Beat intake and command queue.
    tnaa_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_vertex_slot   (s_vertex_slot),
        .s_pos_x_in      (s_pos_x_in),
        .s_pos_y_in      (s_pos_y_in),
        .s_pos_z_in      (s_pos_z_in),
        .s_corner_first  (s_corner_first),
        .s_corner_second (s_corner_second),
        .s_corner_third  (s_corner_third),
        .cmd_valid       (cmd_valid),
        .cmd             (cmd),
        .cmd_pop         (cmd_pop)
    );

    // Command execution and result register.
    tnaa_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .norm_start    (norm_start),
        .norm_req      (norm_req),
        .norm_done     (norm_done),
        .norm_rsp      (norm_rsp),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_unit_x      (m_unit_x),
        .m_unit_y      (m_unit_y),
        .m_unit_z      (m_unit_z),
        .m_double_area (m_double_area),
        .m_degenerate  (m_degenerate)
    );

    // Vector normalizer.
    tnaa_norm u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (norm_start),
        .req     (norm_req),
        .done    (norm_done),
        .rsp     (norm_rsp)
    );

endmodule
